@@ sv/atnd_pkg.sv @@
// shared constants, register codes and token types for the address to index mapper
package atnd_pkg;

  localparam int MaxDims    = 4;
  localparam int ExtentRegs = 4;
  localparam int UsedDims   = (MaxDims < ExtentRegs) ? MaxDims : ExtentRegs;
  localparam int RemSlots   = (UsedDims > 1) ? UsedDims - 1 : 1;
  localparam int AddrW      = 64;
  localparam int ExtW       = 16;
  localparam int CntW       = 3;
  localparam int CfgIdxW    = 3;
  localparam int QuotBits   = AddrW;

  typedef enum logic [CfgIdxW-1:0] {
    RegBase,
    RegElemSize,
    RegDimCount,
    RegDim0,
    RegDim1,
    RegDim2,
    RegDim3
  } cfg_reg_e;

  // one request as it moves along the divider cells
  typedef struct packed {
    logic                           valid;
    logic [AddrW-1:0]               dvd;
    logic [ExtW-1:0]                rem;
    logic [AddrW-1:0]               off;
    logic                           ge;
    logic                           inr;
    logic [AddrW-1:0]               flat;
    logic [AddrW-1:0]               last;
    logic [RemSlots-1:0][ExtW-1:0]  rems;
  } atnd_tok_t;

  typedef struct packed {
    logic                             inr;
    logic [AddrW-1:0]                 flat;
    logic [ExtentRegs-1:0][AddrW-1:0] idx;
  } atnd_res_t;

  // effective configuration seen by the datapath
  typedef struct packed {
    logic [AddrW-1:0]                base;
    logic [ExtW-1:0]                 esize;
    logic [ExtentRegs-1:0][ExtW-1:0] ext;
    logic [CntW-1:0]                 ndims;
    logic [AddrW-1:0]                span;
    logic                            wrap;
  } atnd_cfg_t;

endpackage

@@ sv/atnd_div_cell.sv @@
// one restoring division cell: one quotient bit per cycle while en_i is high
module atnd_div_cell import atnd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  atnd_tok_t       tok_i,
  input  logic [ExtW-1:0] div_i,
  output atnd_tok_t       tok_o
);

  logic [ExtW:0] trial;
  logic          fits;
  atnd_tok_t     tok_d;
  atnd_tok_t     tok_q;
  logic          valid_q;

  always_comb begin
    trial = {tok_i.rem, tok_i.dvd[AddrW-1]};
    fits  = trial >= {1'b0, div_i};
    tok_d = tok_i;
    tok_d.rem = fits ? ExtW'(trial - {1'b0, div_i}) : trial[ExtW-1:0];
    tok_d.dvd = {tok_i.dvd[AddrW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok_q <= tok_d;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

endmodule

@@ sv/atnd_cfg.sv @@
// configuration registers and the registered region span product
module atnd_cfg import atnd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  logic [CfgIdxW-1:0] idx_i,
  input  logic [AddrW-1:0]   data_i,
  output atnd_cfg_t          cfg_o
);

  logic [AddrW-1:0]                base_q;
  logic [ExtW-1:0]                 esize_q;
  logic [CntW-1:0]                 cnt_q;
  logic [ExtentRegs-1:0][ExtW-1:0] dim_q;

  logic [ExtW-1:0]                 esize_eff;
  logic [ExtentRegs-1:0][ExtW-1:0] ext_eff;
  logic [ExtentRegs-1:0][ExtW-1:0] ext_used;
  logic [CntW-1:0]                 ndims;

  logic [2*ExtW-1:0] p01_q, p23_q;
  logic [ExtW-1:0]   es1_q, es2_q;
  logic [AddrW-1:0]  p_q, span_q;
  logic              wrap_q;
  logic [AddrW:0]    end_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      esize_q <= ExtW'(1);
      cnt_q   <= CntW'(1);
      dim_q   <= {ExtentRegs{ExtW'(1)}};
    end else if (wr_i) begin
      case (cfg_reg_e'(idx_i))
        RegBase:     base_q   <= data_i;
        RegElemSize: esize_q  <= data_i[ExtW-1:0];
        RegDimCount: cnt_q    <= data_i[CntW-1:0];
        RegDim0:     dim_q[0] <= data_i[ExtW-1:0];
        RegDim1:     dim_q[1] <= data_i[ExtW-1:0];
        RegDim2:     dim_q[2] <= data_i[ExtW-1:0];
        RegDim3:     dim_q[3] <= data_i[ExtW-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    esize_eff = (esize_q == '0) ? ExtW'(1) : esize_q;
    if (cnt_q == '0) begin
      ndims = CntW'(1);
    end else if (int'(cnt_q) > UsedDims) begin
      ndims = CntW'(UsedDims);
    end else begin
      ndims = cnt_q;
    end
    for (int d = 0; d < ExtentRegs; d++) begin
      ext_eff[d]  = (dim_q[d] == '0) ? ExtW'(1) : dim_q[d];
      ext_used[d] = (d < int'(ndims)) ? ext_eff[d] : ExtW'(1);
    end
  end

  // span = esize * product of used extents, registered after the pair products, their product and the esize multiply
  always_ff @(posedge clk_i) begin
    p01_q  <= ext_used[0] * ext_used[1];
    p23_q  <= ext_used[2] * ext_used[3];
    es1_q  <= esize_eff;
    p_q    <= p01_q * p23_q;
    es2_q  <= es1_q;
    span_q <= AddrW'(p_q * es2_q);
    wrap_q <= end_sum[AddrW];
  end

  assign end_sum = {1'b0, base_q} + {1'b0, span_q};

  always_comb begin
    cfg_o.base  = base_q;
    cfg_o.esize = esize_eff;
    cfg_o.ext   = ext_eff;
    cfg_o.ndims = ndims;
    cfg_o.span  = span_q;
    cfg_o.wrap  = wrap_q;
  end

endmodule

@@ sv/atnd_skid.sv @@
// two-entry output queue that decouples the cell chain from the result stall
module atnd_skid import atnd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  atnd_res_t res_i,
  input  logic      stall_i,
  output logic      valid_o,
  output atnd_res_t res_o,
  output logic      full_o
);

  atnd_res_t  mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign pop     = valid_o && !stall_i;
  assign res_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= res_i;
    end
  end

endmodule

@@ sv/address_to_nd_index.sv @@
// top level: byte address to flat and per-dimension element index
//
//  channel   signals                               dir
//  request   in_valid_i  in_stall_o  address_i     in
//  result    out_valid_o out_stall_i in_range_o    out
//            flat_index_o index_dim0_o..3_o
//  config    cfg_valid_i cfg_ready_o cfg_index_i   in
//            cfg_data_i
//
// one request per cycle while in_stall_o is low; each division cell row holds one cell per quotient bit; four rows
// (element size, then dimensions zero to two), then the output queue
// reset clears every cell valid bit and the queue count; config registers reset to base 0, the rest to 1
// in_stall_o rises only when the two-entry output queue is full; the whole cell
// chain then holds until a result is taken
module address_to_nd_index import atnd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [AddrW-1:0]   address_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               in_range_o,
  output logic [AddrW-1:0]   flat_index_o,
  output logic [AddrW-1:0]   index_dim0_o,
  output logic [AddrW-1:0]   index_dim1_o,
  output logic [AddrW-1:0]   index_dim2_o,
  output logic [AddrW-1:0]   index_dim3_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [AddrW-1:0]   cfg_data_i
);

  atnd_cfg_t cfg;
  logic      en;
  logic      full;
  atnd_res_t res, res_out;

  // tok[k][0] enters row k, tok[k][QuotBits] leaves it
  atnd_tok_t tok  [UsedDims][QuotBits+1];
  atnd_tok_t seam [UsedDims+1];

  // config writes are always taken; software must write only while idle, as the block has no check for it
  assign cfg_ready_o = 1'b1;

  atnd_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_valid_i),
    .idx_i  (cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  assign en         = !full;
  assign in_stall_o = full;

  // entry: wrapped offset feeds the first division
  always_comb begin
    seam[0]       = '0;
    seam[0].valid = in_valid_i;
    seam[0].off   = address_i - cfg.base;
    seam[0].ge    = address_i >= cfg.base;
    seam[0].dvd   = address_i - cfg.base;
  end

  for (genvar k = 0; k < UsedDims; k++) begin : g_row
    logic [ExtW-1:0] divisor;
    assign divisor   = (k == 0) ? cfg.esize : cfg.ext[(k == 0) ? 0 : k - 1];
    assign tok[k][0] = seam[k];

    for (genvar b = 0; b < QuotBits; b++) begin : g_cell
      atnd_div_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .tok_i  (tok[k][b]),
        .div_i  (divisor),
        .tok_o  (tok[k][b+1])
      );
    end

    // fold the finished division into the token before the next row
    if (k == 0) begin : g_first
      always_comb begin
        seam[k+1]      = tok[k][QuotBits];
        seam[k+1].rem  = '0;
        seam[k+1].flat = tok[k][QuotBits].dvd;
        // inside [base, base+span) when the end does not wrap
        seam[k+1].inr  = tok[k][QuotBits].ge && !cfg.wrap &&
                         (tok[k][QuotBits].off < cfg.span);
        seam[k+1].off  = '0;
        if (int'(cfg.ndims) == 1) begin
          seam[k+1].last = tok[k][QuotBits].dvd;
        end
      end
    end else begin : g_next
      always_comb begin
        seam[k+1]         = tok[k][QuotBits];
        seam[k+1].rem     = '0;
        seam[k+1].rems[k-1] = tok[k][QuotBits].rem;
        if (int'(cfg.ndims) == k + 1) begin
          seam[k+1].last = tok[k][QuotBits].dvd;
        end
      end
    end
  end

  // pick remainder, final quotient or zero per dimension
  always_comb begin
    res.inr  = seam[UsedDims].inr;
    res.flat = seam[UsedDims].flat;
    for (int d = 0; d < ExtentRegs; d++) begin
      if (d < int'(cfg.ndims) - 1 && d < RemSlots) begin
        res.idx[d] = AddrW'(seam[UsedDims].rems[d]);
      end else if (d == int'(cfg.ndims) - 1) begin
        res.idx[d] = seam[UsedDims].last;
      end else begin
        res.idx[d] = '0;
      end
    end
  end

  atnd_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (seam[UsedDims].valid && en),
    .res_i   (res),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .res_o   (res_out),
    .full_o  (full)
  );

  assign in_range_o   = res_out.inr;
  assign flat_index_o = res_out.flat;
  assign index_dim0_o = res_out.idx[0];
  assign index_dim1_o = res_out.idx[1];
  assign index_dim2_o = res_out.idx[2];
  assign index_dim3_o = res_out.idx[3];

endmodule

@@ sv/atnd_checker.sv @@
// port-level checks for the address to index mapper, bound to the top level
module atnd_checker import atnd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             in_range_o,
  input logic [AddrW-1:0] flat_index_o
);

  // a held result keeps its flat index and in-range flag
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(flat_index_o)
      && $stable(in_range_o))
    else $error("result changed while stalled");

  // the request side only backs up behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("request stalled with no result waiting");

  // a result leaves only when it was taken
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> !$past(out_stall_i))
    else $error("result dropped");

endmodule

bind address_to_nd_index atnd_checker u_atnd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .in_range_o   (in_range_o),
  .flat_index_o (flat_index_o)
);
